// ===== design/lut_layout_stream_validator_defines.svh =====
// ============================================================================
// Assertion macros for the LUT layout stream validator
// Shared helpers that wrap concurrent assertions on clk and rst_n.
// ============================================================================
`ifndef LUT_LAYOUT_STREAM_VALIDATOR_DEFINES_SVH
`define LUT_LAYOUT_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define LLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lls assertion failed");

// Next-cycle implication, checked outside of reset.
`define LLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lls assertion failed");

`endif

// ===== design/lls_pkg.sv =====
// ============================================================================
// LUT layout stream validator package
// Shared constants, parse phase encoding and transfer types.
// ============================================================================
package lls_pkg;

    // Field widths of the byte stream and of the assembled words.
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;

    // Default number of definition bytes per LUT.
    localparam int LUT_DEF_BYTES_DEFAULT = 8;

    // A LUT index with all bits set always passes the range check.
    localparam logic [WORD_W-1:0] LUT_INDEX_ANY = 16'hFFFF;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Parse phases of the layout walk.
    typedef enum logic [3:0] {
        PH_LUT_COUNT,
        PH_SKIP,
        PH_BLOCK_COUNT,
        PH_IN_TRITS,
        PH_SITE_COUNT,
        PH_LUT_INDEX,
        PH_INPUT_COUNT,
        PH_INPUT_INDEX,
        PH_OUT_COUNT,
        PH_OUT_INDEX,
        PH_DONE
    } phase_t;

    // One queued byte with its end-of-image mark.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } token_t;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic   valid;
        token_t token;
    } queue_head_t;

endpackage

// ===== design/lls_queue.sv =====
// ============================================================================
// LUT layout stream validator front queue
// Accepts image bytes, tags them with the last mark and buffers them.
// ============================================================================
`include "lut_layout_stream_validator_defines.svh"

module lls_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lls_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         last_byte,
    input  logic                         pop,
    output lls_pkg::queue_head_t         head
);

    lls_pkg::token_t                    entry_reg [lls_pkg::QUEUE_DEPTH];
    logic [lls_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [lls_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [lls_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [lls_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [lls_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [lls_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                               push;
    logic                               full;

    // An input transfer is taken whenever a slot is free.
    assign full     = (count_reg == lls_pkg::QUEUE_CNT_W'(lls_pkg::QUEUE_DEPTH));
    assign in_stall = full;
    assign push     = in_valid && !full;

    // Head of the queue.
    assign head.valid = (count_reg != '0);
    assign head.token = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{data: data_byte, last: last_byte};
        end
    end

    // The fill count never exceeds the depth, and the back only pops real entries.
    `LLS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= lls_pkg::QUEUE_CNT_W'(lls_pkg::QUEUE_DEPTH))
    `LLS_ASSERT_IMPL(a_pop_nonempty, pop, count_reg != '0)
    `LLS_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== design/lls_back.sv =====
// ============================================================================
// LUT layout stream validator parse engine
// Walks the layout one byte per cycle unless the result slot stalls; gives the verdict.
// ============================================================================
`include "lut_layout_stream_validator_defines.svh"

module lls_back
#(
    parameter int LUT_DEF_BYTES = lls_pkg::LUT_DEF_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lls_pkg::queue_head_t  head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  layout_valid
);

    localparam int W      = lls_pkg::WORD_W;
    localparam int SKIP_W = $clog2(((2 ** W) - 1) * LUT_DEF_BYTES + 1);

    lls_pkg::phase_t             phase_reg;
    lls_pkg::phase_t             phase_next;
    logic                        hold_valid_reg;
    logic                        hold_valid_next;
    logic [lls_pkg::BYTE_W-1:0]  hold_byte_reg;
    logic [lls_pkg::BYTE_W-1:0]  hold_byte_next;
    logic                        failed_reg;
    logic                        failed_next;
    logic [W-1:0]                lut_total_reg;
    logic [W-1:0]                lut_total_next;
    logic [SKIP_W-1:0]           skip_reg;
    logic [SKIP_W-1:0]           skip_next;
    logic [W-1:0]                blocks_reg;
    logic [W-1:0]                blocks_next;
    logic [W-1:0]                trits_reg;
    logic [W-1:0]                trits_next;
    logic [W-1:0]                bound_reg;
    logic [W-1:0]                bound_next;
    logic [W-1:0]                sites_reg;
    logic [W-1:0]                sites_next;
    logic [W-1:0]                indexes_reg;
    logic [W-1:0]                indexes_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        verdict_reg;
    logic                        verdict_next;
    logic [W-1:0]                word;
    logic [W-1:0]                sites_dec;
    logic [W-1:0]                blocks_dec;
    logic [W-1:0]                indexes_dec;
    logic                        end_image;
    logic                        verdict_ok;

    // A head byte is popped unless it ends the image and the full result slot is stalled.
    assign pop       = head.valid && (!head.token.last || !out_valid_reg || !out_stall);
    assign end_image = pop && head.token.last;

    assign word        = {head.token.data, hold_byte_reg};
    assign sites_dec   = sites_reg - 1'b1;
    assign blocks_dec  = blocks_reg - 1'b1;
    assign indexes_dec = indexes_reg - 1'b1;

    // Next state of the parse walk for the byte at the queue head.
    always_comb
    begin
        phase_next      = phase_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        failed_next     = failed_reg;
        lut_total_next  = lut_total_reg;
        skip_next       = skip_reg;
        blocks_next     = blocks_reg;
        trits_next      = trits_reg;
        bound_next      = bound_reg;
        sites_next      = sites_reg;
        indexes_next    = indexes_reg;
        if (pop && !failed_reg)
        begin
            priority if (phase_reg == lls_pkg::PH_DONE)
            begin
                // Trailing byte after a complete structure.
                failed_next = 1'b1;
            end
            else if (phase_reg == lls_pkg::PH_SKIP)
            begin
                skip_next = skip_reg - 1'b1;
                if (skip_reg == SKIP_W'(1))
                begin
                    phase_next = lls_pkg::PH_BLOCK_COUNT;
                end
            end
            else if (!hold_valid_reg)
            begin
                hold_valid_next = 1'b1;
                hold_byte_next  = head.token.data;
            end
            else
            begin
                hold_valid_next = 1'b0;
                unique case (phase_reg)
                    lls_pkg::PH_LUT_COUNT:
                    begin
                        lut_total_next = word;
                        skip_next      = SKIP_W'(word) * SKIP_W'(LUT_DEF_BYTES);
                        phase_next     = (word == '0) ? lls_pkg::PH_BLOCK_COUNT
                                                      : lls_pkg::PH_SKIP;
                    end
                    lls_pkg::PH_BLOCK_COUNT:
                    begin
                        blocks_next = word;
                        phase_next  = (word == '0) ? lls_pkg::PH_DONE : lls_pkg::PH_IN_TRITS;
                    end
                    lls_pkg::PH_IN_TRITS:
                    begin
                        trits_next = word;
                        phase_next = lls_pkg::PH_SITE_COUNT;
                    end
                    lls_pkg::PH_SITE_COUNT:
                    begin
                        sites_next = word;
                        bound_next = trits_reg + word;
                        phase_next = (word == '0) ? lls_pkg::PH_OUT_COUNT
                                                  : lls_pkg::PH_LUT_INDEX;
                    end
                    lls_pkg::PH_LUT_INDEX:
                    begin
                        if (word >= lut_total_reg && word != lls_pkg::LUT_INDEX_ANY)
                        begin
                            failed_next = 1'b1;
                        end
                        phase_next = lls_pkg::PH_INPUT_COUNT;
                    end
                    lls_pkg::PH_INPUT_COUNT:
                    begin
                        indexes_next = word;
                        if (word == '0)
                        begin
                            sites_next = sites_dec;
                            phase_next = (sites_dec == '0) ? lls_pkg::PH_OUT_COUNT
                                                           : lls_pkg::PH_LUT_INDEX;
                        end
                        else
                        begin
                            phase_next = lls_pkg::PH_INPUT_INDEX;
                        end
                    end
                    lls_pkg::PH_INPUT_INDEX:
                    begin
                        if (word >= bound_reg)
                        begin
                            failed_next = 1'b1;
                        end
                        indexes_next = indexes_dec;
                        if (indexes_dec == '0)
                        begin
                            sites_next = sites_dec;
                            phase_next = (sites_dec == '0) ? lls_pkg::PH_OUT_COUNT
                                                           : lls_pkg::PH_LUT_INDEX;
                        end
                    end
                    lls_pkg::PH_OUT_COUNT:
                    begin
                        indexes_next = word;
                        if (word == '0)
                        begin
                            blocks_next = blocks_dec;
                            phase_next  = (blocks_dec == '0) ? lls_pkg::PH_DONE
                                                             : lls_pkg::PH_IN_TRITS;
                        end
                        else
                        begin
                            phase_next = lls_pkg::PH_OUT_INDEX;
                        end
                    end
                    lls_pkg::PH_OUT_INDEX:
                    begin
                        if (word >= bound_reg)
                        begin
                            failed_next = 1'b1;
                        end
                        indexes_next = indexes_dec;
                        if (indexes_dec == '0)
                        begin
                            blocks_next = blocks_dec;
                            phase_next  = (blocks_dec == '0) ? lls_pkg::PH_DONE
                                                             : lls_pkg::PH_IN_TRITS;
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // Verdict and result slot.
    always_comb
    begin
        verdict_ok = !failed_next && (phase_next == lls_pkg::PH_DONE) && !hold_valid_next;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg;
        if (end_image)
        begin
            out_valid_next = 1'b1;
            verdict_next   = verdict_ok;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign layout_valid = verdict_reg;

    // Control state; the end of an image returns the walk to its start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lls_pkg::PH_LUT_COUNT;
            hold_valid_reg <= 1'b0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (end_image)
            begin
                phase_reg      <= lls_pkg::PH_LUT_COUNT;
                hold_valid_reg <= 1'b0;
                failed_reg     <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                hold_valid_reg <= hold_valid_next;
                failed_reg     <= failed_next;
            end
        end
    end

    // Counters and held data are always written before they are read.
    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        lut_total_reg <= lut_total_next;
        skip_reg      <= skip_next;
        blocks_reg    <= blocks_next;
        trits_reg     <= trits_next;
        bound_reg     <= bound_next;
        sites_reg     <= sites_next;
        indexes_reg   <= indexes_next;
        verdict_reg   <= verdict_next;
    end

    // The end of an image yields a result and restarts the walk.
    `LLS_ASSERT_NEXT(a_end_gives_result, end_image, out_valid_reg)
    `LLS_ASSERT_NEXT(a_end_restarts, end_image, phase_reg == lls_pkg::PH_LUT_COUNT && !hold_valid_reg && !failed_reg)
    `LLS_ASSERT_NEXT(a_failure_sticks, failed_reg && !end_image, failed_reg)
    `LLS_ASSERT_IMPL(a_no_overwrite, out_valid_reg && out_stall, !end_image)

endmodule

// ===== design/lut_layout_stream_validator.sv =====
// Verdict path: the last byte is written into the queue, popped by the parse engine after
// every byte queued ahead of it, and its verdict is registered in the result slot.
// Throughput: one byte per cycle while a queue slot is free, also while a verdict waits.
// The four-entry queue decouples input from the engine's unstalled one byte per cycle.
// Reset: rst_n clears the queue, the parse walk and the result slot at once.
// ============================================================================
// LUT layout stream validator
// Checks a byte-serial LUT network layout image and reports one verdict per image.
// ============================================================================
module lut_layout_stream_validator
#(
    parameter int LUT_DEF_BYTES = lls_pkg::LUT_DEF_BYTES_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lls_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        layout_valid
);

    lls_pkg::queue_head_t  head;
    logic                  pop;

    // Front: takes byte transfers into the queue.
    lls_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .pop       (pop),
        .head      (head)
    );

    // Back: walks the structure and holds the verdict.
    lls_back
    #(
        .LUT_DEF_BYTES (LUT_DEF_BYTES)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .layout_valid (layout_valid)
    );

endmodule

// ===== test/tb_lut_layout_stream_validator.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the LUT layout stream validator
// Streams short layout images with random content and occasional damage,
// tracks the layout walk in a local parse model, and checks each verdict.
// ============================================================================
module tb_lut_layout_stream_validator;

    localparam int DEF_BYTES   = lls_pkg::LUT_DEF_BYTES_DEFAULT;
    localparam int ITEM_TARGET = 1400;
    localparam int MIN_IMAGES  = 45;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;

    // Parse model of the layout walk, with the verdicts still due.
    class layout_walk_model;
        lls_pkg::phase_t phase;
        logic [8:0]      held;
        logic [15:0]     lut_total;
        logic [18:0]     skip_left;
        logic [15:0]     blocks_left;
        logic [15:0]     trit_count;
        logic [15:0]     site_bound;
        logic [15:0]     sites_left;
        logic [15:0]     index_left;
        bit              failed;
        bit              pending_verdicts[$];
        int              mismatch_count;

        function new();
            clear_walk();
            mismatch_count = 0;
        endfunction

        function void clear_walk();
            phase       = lls_pkg::PH_LUT_COUNT;
            held        = '0;
            lut_total   = '0;
            skip_left   = '0;
            blocks_left = '0;
            trit_count  = '0;
            site_bound  = '0;
            sites_left  = '0;
            index_left  = '0;
            failed      = 1'b0;
        endfunction

        function int pending_count();
            return pending_verdicts.size();
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        // Advance the walk by one accepted byte; the last byte yields a verdict.
        task accept_byte(input logic [7:0] b, input logic fin);
            logic [15:0] w;
            if (!failed)
            begin
                if (phase == lls_pkg::PH_DONE)
                begin
                    failed = 1'b1;
                end
                else if (phase == lls_pkg::PH_SKIP)
                begin
                    skip_left = skip_left - 1'b1;
                    if (skip_left == 0)
                        phase = lls_pkg::PH_BLOCK_COUNT;
                end
                else if (!held[8])
                begin
                    held = {1'b1, b};
                end
                else
                begin
                    w    = {b, held[7:0]};
                    held = '0;
                    case (phase)
                        lls_pkg::PH_LUT_COUNT:
                        begin
                            lut_total = w;
                            skip_left = w * DEF_BYTES;
                            phase = (skip_left == 0) ? lls_pkg::PH_BLOCK_COUNT
                                                     : lls_pkg::PH_SKIP;
                        end
                        lls_pkg::PH_BLOCK_COUNT:
                        begin
                            blocks_left = w;
                            phase = (blocks_left == 0) ? lls_pkg::PH_DONE
                                                       : lls_pkg::PH_IN_TRITS;
                        end
                        lls_pkg::PH_IN_TRITS:
                        begin
                            trit_count = w;
                            phase = lls_pkg::PH_SITE_COUNT;
                        end
                        lls_pkg::PH_SITE_COUNT:
                        begin
                            sites_left = w;
                            site_bound = trit_count + w;
                            phase = (sites_left == 0) ? lls_pkg::PH_OUT_COUNT
                                                      : lls_pkg::PH_LUT_INDEX;
                        end
                        lls_pkg::PH_LUT_INDEX:
                        begin
                            if (w >= lut_total && w != lls_pkg::LUT_INDEX_ANY)
                                failed = 1'b1;
                            phase = lls_pkg::PH_INPUT_COUNT;
                        end
                        lls_pkg::PH_INPUT_COUNT, lls_pkg::PH_INPUT_INDEX:
                        begin
                            if (phase == lls_pkg::PH_INPUT_COUNT)
                            begin
                                index_left = w;
                            end
                            else
                            begin
                                if (w >= site_bound)
                                    failed = 1'b1;
                                index_left = index_left - 1'b1;
                            end
                            if (index_left == 0)
                            begin
                                sites_left = sites_left - 1'b1;
                                phase = (sites_left == 0) ? lls_pkg::PH_OUT_COUNT
                                                          : lls_pkg::PH_LUT_INDEX;
                            end
                            else
                            begin
                                phase = lls_pkg::PH_INPUT_INDEX;
                            end
                        end
                        lls_pkg::PH_OUT_COUNT, lls_pkg::PH_OUT_INDEX:
                        begin
                            if (phase == lls_pkg::PH_OUT_COUNT)
                            begin
                                index_left = w;
                            end
                            else
                            begin
                                if (w >= site_bound)
                                    failed = 1'b1;
                                index_left = index_left - 1'b1;
                            end
                            if (index_left == 0)
                            begin
                                blocks_left = blocks_left - 1'b1;
                                phase = (blocks_left == 0) ? lls_pkg::PH_DONE
                                                           : lls_pkg::PH_IN_TRITS;
                            end
                            else
                            begin
                                phase = lls_pkg::PH_OUT_INDEX;
                            end
                        end
                        default:
                        begin
                            failed = 1'b1;
                        end
                    endcase
                end
            end
            if (fin)
            begin
                pending_verdicts.push_back(!failed && phase == lls_pkg::PH_DONE && !held[8]);
                clear_walk();
            end
        endtask

        // Compare one delivered verdict with the oldest one due.
        task compare_verdict(input logic got);
            bit want;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("verdict %b with none due", got));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("layout_valid %b, want %b", got, want));
            end
        endtask
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte    = '0;
    logic       last_byte    = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic       layout_valid;

    logic       hold_off     = 1'b0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         bytes_offered = 0;
    int         bytes_accepted = 0;
    int         images_sent   = 0;
    logic [7:0] image_bytes[$];

    layout_walk_model walk = new();

    lut_layout_stream_validator
    #(
        .LUT_DEF_BYTES (DEF_BYTES)
    )
    uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .layout_valid (layout_valid)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watch both channels and feed every transfer to the parse model.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                walk.accept_byte(data_byte, last_byte);
                bytes_accepted++;
            end
            if (out_valid && !out_stall)
                walk.compare_verdict(layout_valid);
        end
    end

    // Receiver: random stall, plus the long hold-off when requested.
    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    // Long receiver hold-off while the sender keeps offering bytes.
    initial
    begin
        wait (bytes_accepted >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Run limit.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one byte, with a random gap before it, and wait for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        bytes_offered++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_image();
        for (int i = 0; i < image_bytes.size(); i++)
            send_byte(image_bytes[i], i == image_bytes.size() - 1);
        images_sent++;
    endtask

    task automatic put_word(input logic [15:0] w);
        image_bytes.push_back(w[7:0]);
        image_bytes.push_back(w[15:8]);
    endtask

    // LUT index: mostly in range, sometimes the wildcard, the count itself or anything.
    function automatic logic [15:0] pick_lut_index(input int unsigned luts);
        case ($urandom_range(0, 15))
            0: return lls_pkg::LUT_INDEX_ANY;
            1: return 16'(luts);
            2: return 16'($urandom_range(0, 16'hFFFF));
            default: return (luts == 0) ? lls_pkg::LUT_INDEX_ANY
                                        : 16'($urandom_range(0, luts - 1));
        endcase
    endfunction

    // Input or output index: mostly below the bound, sometimes at or near it.
    function automatic logic [15:0] pick_site_index(input logic [15:0] bound);
        case ($urandom_range(0, 15))
            0: return bound;
            1: return bound - 1'b1;
            2: return 16'($urandom_range(0, 16'hFFFF));
            default: return (bound == 0) ? 16'h0000 : 16'($urandom_range(0, bound - 1));
        endcase
    endfunction

    // Build a well-formed image with random content, then now and then damage it.
    task automatic build_image();
        int unsigned luts;
        int unsigned blocks;
        int unsigned sites;
        int unsigned count;
        int unsigned cut;
        logic [15:0] trits;
        logic [15:0] bound;
        image_bytes.delete();
        luts = $urandom_range(0, 3);
        put_word(16'(luts));
        repeat (luts * DEF_BYTES) image_bytes.push_back(8'($urandom_range(0, 255)));
        blocks = $urandom_range(0, 2);
        put_word(16'(blocks));
        repeat (blocks)
        begin
            case ($urandom_range(0, 15))
                0, 1: trits = 16'hFFFF - 16'($urandom_range(0, 3));
                2: trits = 16'($urandom_range(0, 16'hFFFF));
                default: trits = 16'($urandom_range(0, 6));
            endcase
            sites = $urandom_range(0, 3);
            bound = trits + 16'(sites);
            put_word(trits);
            put_word(16'(sites));
            repeat (sites)
            begin
                put_word(pick_lut_index(luts));
                count = $urandom_range(0, 3);
                put_word(16'(count));
                repeat (count) put_word(pick_site_index(bound));
            end
            count = $urandom_range(0, 3);
            put_word(16'(count));
            repeat (count) put_word(pick_site_index(bound));
        end
        case ($urandom_range(0, 19))
            0, 1:
            begin
                // Truncated image, possibly in the middle of a word.
                cut = $urandom_range(1, image_bytes.size() - 1);
                while (image_bytes.size() > cut)
                    void'(image_bytes.pop_back());
            end
            2:
            begin
                // Bytes after a complete structure.
                repeat ($urandom_range(1, 3)) image_bytes.push_back(8'($urandom_range(0, 255)));
            end
            3:
            begin
                // Pure noise.
                image_bytes.delete();
                repeat ($urandom_range(1, 6)) image_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
            end
        endcase
    endtask

    // Main sequence: reset, directed images, three random phases, drain.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest well-formed image: no LUTs, no blocks.
        image_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_image();
        // Last byte while half a word is held.
        image_bytes = '{8'h00};
        send_image();
        // Largest LUT count, cut off while skipping definitions.
        image_bytes = '{8'hFF, 8'hFF, 8'hA5};
        send_image();
        // A byte after the structure is complete.
        image_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h5A};
        send_image();
        // Output index equal to the bound of its block.
        image_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
                        8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00};
        send_image();

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 27;
                    stall_pct     = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    stall_pct     = 27;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            while (bytes_offered < ITEM_TARGET * (p + 1) / 3 ||
                   (p == 2 && images_sent < MIN_IMAGES))
            begin
                build_image();
                send_image();
            end
        end
        in_valid <= 1'b0;

        while (walk.pending_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (walk.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
